// File: hw/rtl/best_fit_extent_allocator_unit_defines.svh
// Assertion macros used by the extent allocator top level
`ifndef BEST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock once reset is released
`define BFEA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bfea: property violated");
// Condition must never be seen once reset is released
`define BFEA_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bfea: forbidden condition seen");
`else
`define BFEA_ASSERT(lbl, prop)
`define BFEA_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/bfea_pkg.sv
// Types and constants shared by the extent allocator cells and control
package bfea_pkg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } extent_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_SHL,
        CELL_SHR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     x_wr;
        extent_t  x;
    } cell_cmd_t;

    localparam logic       OP_FREE    = 1'b0;
    localparam logic       OP_ALLOC   = 1'b1;
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [31:0] BLK_MAX   = 32'hFFFF_FFFF;
    localparam logic [32:0] BLK_MAX33 = {1'b0, BLK_MAX};

endpackage

// File: hw/rtl/bfea_cell.sv
// One slot of the extent chain: holds one extent, trades with its neighbors
module bfea_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  bfea_pkg::cell_cmd_t cmd,
    input  logic [CNT_W-1:0]    base,
    input  logic [CNT_W-1:0]    xpos,
    input  bfea_pkg::extent_t   left_ent,
    input  bfea_pkg::extent_t   right_ent,
    output bfea_pkg::extent_t   ent
);
    import bfea_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    extent_t ent_reg;
    extent_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            CELL_ROT:
            begin
                ent_next = right_ent;
            end
            CELL_SHL:
            begin
                if (MY_IDX >= base)
                begin
                    ent_next = right_ent;
                end
            end
            CELL_SHR:
            begin
                if (MY_IDX >= base)
                begin
                    ent_next = left_ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
        // a direct write wins over any shift
        if (cmd.x_wr && (MY_IDX == xpos))
        begin
            ent_next = cmd.x;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// File: hw/rtl/best_fit_extent_allocator_unit.sv
// Top level of the best-fit free extent allocator: control plus row of cells
//
// Requests come in on req_valid/req_ready with operation, block_start and
// block_count; one response per request leaves on rsp_valid/rsp_ready with
// position and status. A free (operation 0) inserts or widens an extent and
// coalesces it with its neighbors; an allocate (operation 1) takes the
// smallest fitting extent, lowest start on a tie, and returns its start.
// The free list lives in a row of MAX_EXTENTS cells, sorted by start.
// A request first rotates the whole row once past cell 0, one extent per
// cycle unless a free pauses at its insertion point, while the scan logic
// reads each extent in order; then a short edit phase writes the new
// extent and shifts cells left or right. One request is in work at a
// time, and a new beat is taken as soon as the previous response sits in
// the output register. A stalled receiver holds the response; a finished
// request then waits in the response state. Reset empties the table,
// which means the whole block space is free.
module best_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        operation,
    input  logic [31:0] block_start,
    input  logic [31:0] block_count,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] position,
    output logic [1:0]  status
);
    import bfea_pkg::*;

    `include "best_fit_extent_allocator_unit_defines.svh"

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [CNT_W-1:0] K_MAX = CNT_W'(MAX_EXTENTS);
    localparam logic [CNT_W-1:0] K_ONE = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_EDIT,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_PREV,
        PH_MERGE,
        PH_BEST,
        PH_DONE
    } phase_t;

    state_t           state_reg;
    phase_t           ph_reg;
    logic [CNT_W-1:0] u_reg;
    logic [CNT_W-1:0] k_reg;
    logic             op_reg;
    logic [31:0]      blk_reg;
    logic [31:0]      cnt_reg;
    logic             have_prev_reg;
    logic [31:0]      prev_start_reg;
    logic [32:0]      prev_end_reg;
    logic [32:0]      nend_reg;
    logic [32:0]      end_reg;
    logic [31:0]      xs_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] p_reg;
    logic [CNT_W-1:0] q_reg;
    logic             noedit_reg;
    logic             found_reg;
    logic             stop_reg;
    logic [CNT_W-1:0] best_reg;
    logic [31:0]      best_len_reg;
    logic [31:0]      best_start_reg;
    logic [1:0]       stat_reg;
    logic [31:0]      pos_reg;
    logic             x_pend_reg;
    logic             shr_pend_reg;
    logic [CNT_W-1:0] shl_cnt_reg;
    logic [CNT_W-1:0] base_reg;
    logic [CNT_W-1:0] xpos_reg;
    extent_t          x_reg;
    logic             rsp_valid_reg;
    logic [31:0]      position_reg;
    logic [1:0]       status_reg;

    extent_t   ent [MAX_EXTENTS];
    cell_cmd_t cmd;
    extent_t   head;
    logic      hv;
    logic      head_lt;
    logic      match;
    logic      rotate;
    logic [32:0] head_end;
    logic [31:0] nlen0;
    logic [32:0] nsum;
    logic        fits;
    logic        better;
    logic        prev_merge;
    logic [32:0] xlen_wide;
    logic [31:0] xlen;

    // row of cells; cell 0 is the head read by the scan
    for (genvar g = 0; g < MAX_EXTENTS; g++)
    begin : g_cell
        bfea_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .base      (base_reg),
            .xpos      (xpos_reg),
            .left_ent  (ent[(g + MAX_EXTENTS - 1) % MAX_EXTENTS]),
            .right_ent (ent[(g + 1) % MAX_EXTENTS]),
            .ent       (ent[g])
        );
    end

    assign head     = ent[0];
    assign hv       = (k_reg < u_reg);
    assign head_end = {1'b0, head.start} + {1'b0, head.len};
    assign head_lt  = (head.start < blk_reg);
    assign match    = hv && (head.start == blk_reg);
    // widen a same-start extent, then clip at the top of the space
    assign nlen0    = (match && (head.len > cnt_reg)) ? head.len : cnt_reg;
    assign nsum     = {1'b0, blk_reg} + {1'b0, nlen0};
    assign fits     = (head.len >= cnt_reg);
    assign better   = !found_reg || (best_len_reg > head.len);
    assign prev_merge = have_prev_reg && (prev_end_reg >= {1'b0, blk_reg});
    assign xlen_wide  = end_reg - {1'b0, xs_reg};
    assign xlen       = xlen_wide[32] ? BLK_MAX : xlen_wide[31:0];

    // advance the row when the scan consumes the head extent; best-fit and done phases run on to a full turn
    always_comb
    begin
        rotate = 1'b0;
        if (state_reg == ST_SCAN)
        begin
            case (ph_reg)
                PH_SEEK:  rotate = (hv && head_lt) || match;
                PH_MERGE: rotate = hv && ({1'b0, head.start} <= end_reg);
                PH_BEST:  rotate = (k_reg != K_MAX);
                PH_DONE:  rotate = (k_reg != K_MAX);
                default:  rotate = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        cmd.op   = CELL_HOLD;
        cmd.x_wr = 1'b0;
        cmd.x    = x_reg;
        case (state_reg)
            ST_SCAN:
            begin
                cmd.op = rotate ? CELL_ROT : CELL_HOLD;
            end
            ST_EDIT:
            begin
                cmd.x_wr = x_pend_reg;
                if (shr_pend_reg)
                begin
                    cmd.op = CELL_SHR;
                end
                else if (shl_cnt_reg != '0)
                begin
                    cmd.op = CELL_SHL;
                end
            end
            default:
            begin
                cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ph_reg         <= PH_SEEK;
            u_reg          <= '0;
            k_reg          <= '0;
            op_reg         <= OP_FREE;
            blk_reg        <= '0;
            cnt_reg        <= '0;
            have_prev_reg  <= 1'b0;
            prev_start_reg <= '0;
            prev_end_reg   <= '0;
            nend_reg       <= '0;
            end_reg        <= '0;
            xs_reg         <= '0;
            i_reg          <= '0;
            p_reg          <= '0;
            q_reg          <= '0;
            noedit_reg     <= 1'b0;
            found_reg      <= 1'b0;
            stop_reg       <= 1'b0;
            best_reg       <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            stat_reg       <= STAT_OK;
            pos_reg        <= '0;
            x_pend_reg     <= 1'b0;
            shr_pend_reg   <= 1'b0;
            shl_cnt_reg    <= '0;
            base_reg       <= '0;
            xpos_reg       <= '0;
            x_reg          <= '0;
            rsp_valid_reg  <= 1'b0;
            position_reg   <= '0;
            status_reg     <= STAT_OK;
        end
        else
        begin
            // drop the beat once taken, unless the response state reloads it
            if (rsp_valid_reg && rsp_ready && (state_reg != ST_RESP))
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (rotate)
            begin
                k_reg <= k_reg + K_ONE;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg        <= operation;
                        blk_reg       <= block_start;
                        cnt_reg       <= block_count;
                        k_reg         <= '0;
                        have_prev_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        stop_reg      <= 1'b0;
                        stat_reg      <= STAT_OK;
                        pos_reg       <= '0;
                        x_pend_reg    <= 1'b0;
                        shr_pend_reg  <= 1'b0;
                        shl_cnt_reg   <= '0;
                        noedit_reg    <= (operation == OP_FREE) && (block_count == '0);
                        if (operation == OP_ALLOC)
                        begin
                            ph_reg <= PH_BEST;
                        end
                        else if (block_count == '0)
                        begin
                            ph_reg <= PH_DONE;
                        end
                        else
                        begin
                            ph_reg <= PH_SEEK;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    case (ph_reg)
                        PH_SEEK:
                        begin
                            if (hv && head_lt)
                            begin
                                prev_start_reg <= head.start;
                                prev_end_reg   <= head_end;
                                have_prev_reg  <= 1'b1;
                            end
                            else
                            begin
                                i_reg <= rotate ? k_reg : k_reg;
                                if (!match && (u_reg == K_MAX))
                                begin
                                    // no room for a new extent: drop the free
                                    stat_reg   <= STAT_FULL;
                                    noedit_reg <= 1'b1;
                                    ph_reg     <= PH_DONE;
                                end
                                else
                                begin
                                    nend_reg <= (nsum > BLK_MAX33) ? BLK_MAX33 : nsum;
                                    ph_reg   <= PH_PREV;
                                end
                            end
                        end
                        PH_PREV:
                        begin
                            if (prev_merge)
                            begin
                                xs_reg  <= prev_start_reg;
                                end_reg <= (prev_end_reg > nend_reg) ? prev_end_reg : nend_reg;
                                p_reg   <= i_reg - K_ONE;
                            end
                            else
                            begin
                                xs_reg  <= blk_reg;
                                end_reg <= nend_reg;
                                p_reg   <= i_reg;
                            end
                            ph_reg <= PH_MERGE;
                        end
                        PH_MERGE:
                        begin
                            if (rotate)
                            begin
                                if (head_end > end_reg)
                                begin
                                    end_reg <= head_end;
                                end
                            end
                            else
                            begin
                                q_reg  <= k_reg;
                                ph_reg <= PH_DONE;
                            end
                        end
                        PH_BEST:
                        begin
                            if (hv && !stop_reg && fits && better)
                            begin
                                best_reg       <= k_reg;
                                best_len_reg   <= head.len;
                                best_start_reg <= head.start;
                                found_reg      <= 1'b1;
                                if (head.len == cnt_reg)
                                begin
                                    stop_reg <= 1'b1;
                                end
                            end
                            if (k_reg == K_MAX)
                            begin
                                state_reg <= ST_PLAN;
                            end
                        end
                        PH_DONE:
                        begin
                            if (k_reg == K_MAX)
                            begin
                                state_reg <= ST_PLAN;
                            end
                        end
                        default:
                        begin
                            ph_reg <= PH_DONE;
                        end
                    endcase
                end
                ST_PLAN:
                begin
                    if (op_reg == OP_FREE)
                    begin
                        if (!noedit_reg)
                        begin
                            x_reg      <= '{start: xs_reg, len: xlen};
                            xpos_reg   <= p_reg;
                            x_pend_reg <= 1'b1;
                            base_reg   <= p_reg + K_ONE;
                            if (q_reg == p_reg)
                            begin
                                shr_pend_reg <= 1'b1;
                            end
                            else
                            begin
                                shl_cnt_reg <= q_reg - p_reg - K_ONE;
                            end
                            u_reg <= u_reg + p_reg + K_ONE - q_reg;
                        end
                    end
                    else if (found_reg)
                    begin
                        pos_reg <= best_start_reg;
                        if (best_len_reg != cnt_reg)
                        begin
                            // keep the remainder of the chosen extent
                            x_reg      <= '{start: best_start_reg + cnt_reg,
                                            len:   best_len_reg - cnt_reg};
                            xpos_reg   <= best_reg;
                            x_pend_reg <= 1'b1;
                        end
                        else if (u_reg == K_ONE)
                        begin
                            // last extent used up: leave a zero-length marker
                            x_reg      <= '0;
                            xpos_reg   <= '0;
                            x_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            base_reg    <= best_reg;
                            shl_cnt_reg <= K_ONE;
                            u_reg       <= u_reg - K_ONE;
                        end
                    end
                    else if (u_reg == '0)
                    begin
                        // empty table: the whole space was free
                        if (cnt_reg != '0)
                        begin
                            x_reg      <= '{start: cnt_reg, len: 32'd0 - cnt_reg};
                            xpos_reg   <= '0;
                            x_pend_reg <= 1'b1;
                            u_reg      <= K_ONE;
                        end
                    end
                    else
                    begin
                        stat_reg <= STAT_NOFIT;
                    end
                    state_reg <= ST_EDIT;
                end
                ST_EDIT:
                begin
                    x_pend_reg   <= 1'b0;
                    shr_pend_reg <= 1'b0;
                    if (shl_cnt_reg != '0)
                    begin
                        shl_cnt_reg <= shl_cnt_reg - K_ONE;
                    end
                    if (shr_pend_reg || (shl_cnt_reg <= K_ONE))
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        position_reg  <= pos_reg;
                        status_reg    <= stat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign position  = position_reg;
    assign status    = status_reg;

    `BFEA_NEVER(a_used_bound, u_reg > K_MAX)
    `BFEA_ASSERT(a_full_rotation, $rose(state_reg == ST_PLAN) |-> (k_reg == K_MAX))
    `BFEA_ASSERT(a_full_only_when_full, (state_reg == ST_RESP) && (stat_reg == STAT_FULL) |-> (u_reg == K_MAX))
    `BFEA_ASSERT(a_used_moves_in_plan, (state_reg != ST_PLAN) |=> $stable(u_reg))

endmodule
